[src/axis_boundary_hit_time_top_assert.svh]
// assertion macros for the boundary hit time block
`ifndef AXIS_BOUNDARY_HIT_TIME_TOP_ASSERT_SVH
`define AXIS_BOUNDARY_HIT_TIME_TOP_ASSERT_SVH

// check held at every edge outside reset
`define ABHT_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check held at every edge, reset included
`define ABHT_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/abht_pkg.sv]
`default_nettype none
package abht_pkg;

  localparam int XW        = 32;
  localparam int ROOT_W    = 33;
  localparam int RAD_W     = 66;
  localparam int SQ_STEPS  = 33;
  localparam int REM_W     = 36;
  localparam int MAG_W     = 34;
  localparam int NUM_LANES = 4;

  typedef struct packed {
    logic signed [XW-1:0] v;
    logic                 a_pos;
    logic                 a_zero;
    logic                 v_zero;
    logic                 fz;
    logic [1:0]           en;
    logic [XW-1:0]        span;
    logic                 dist_ok;
    logic [XW-1:0]        den;
  } sq_side_t;

  typedef struct packed {
    logic [NUM_LANES-1:0] keep;
    logic                 fz;
  } dv_side_t;

  function automatic logic [XW-1:0] mag32(input logic signed [XW-1:0] s);
    logic [XW-1:0] u;
    u = s;
    return s[XW-1] ? (~u + 1'b1) : u;
  endfunction

  function automatic logic [XW-1:0] mag33(input logic signed [XW:0] s);
    logic [XW:0] u;
    u = s[XW] ? (~s + 1'b1) : s;
    return u[XW-1:0];
  endfunction

  function automatic logic [MAG_W-1:0] mag35(input logic signed [MAG_W:0] s);
    logic [MAG_W:0] u;
    u = s[MAG_W] ? (~s + 1'b1) : s;
    return u[MAG_W-1:0];
  endfunction

endpackage
`default_nettype wire

[src/axis_boundary_hit_time_top.sv]
`default_nettype none
// Earliest time for a point on one axis to reach +bound or -bound under constant
// acceleration. One query may be started in every cycle (busy stays low) and its
// result appears on the done strobe for a single cycle. The result passes through
// the square root pipeline (33 stages, one root bit each) and the divider pipeline
// (one quotient bit per stage). The receiver cannot stall, so results must be taken
// in the cycle that done is high.
module axis_boundary_hit_time_top #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] position,
  input  wire logic signed [31:0] velocity,
  input  wire logic signed [31:0] acceleration,
  input  wire logic [30:0]        bound,
  output logic                    done,
  output logic [31:0]             duration,
  output logic                    no_hit,
  output logic                    saturated
);

  localparam int XW  = abht_pkg::XW;
  localparam int MW  = abht_pkg::MAG_W;
  localparam int RW  = abht_pkg::ROOT_W;
  localparam int DW  = abht_pkg::RAD_W;
  localparam int L   = abht_pkg::NUM_LANES;
  localparam int QW  = MW + FRAC_BITS;
  localparam int LAT = 40 + QW;

  assign busy = 1'b0;

  // stage a: input registers
  logic                 a_vld;
  logic signed [XW-1:0] a_x, a_v, a_a;
  logic [30:0]          a_lim;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    a_x   <= position;
    a_v   <= velocity;
    a_a   <= acceleration;
    a_lim <= bound;
  end

  // stage b: offsets to both walls, magnitudes, flags
  logic signed [XW:0] x33, lim33, off1, off2, wall_gap;

  always_comb begin
    x33      = {a_x[XW-1], a_x};
    lim33    = {2'b00, a_lim};
    off1     = x33 - lim33;
    off2     = x33 + lim33;
    wall_gap = (!a_v[XW-1] && a_v != '0) ? -off1 : off2;
  end

  logic            b_vld;
  logic [XW-1:0]   b_vmag, b_amag, b_off1m, b_off2m, b_dist;
  logic            b_ppos1, b_ppos2, b_on_up, b_on_dn, b_a_pos, b_a_zero, b_v_zero;
  logic            b_dist_ok, b_exit;
  logic signed [XW-1:0] b_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    b_v       <= a_v;
    b_vmag    <= abht_pkg::mag32(a_v);
    b_amag    <= abht_pkg::mag32(a_a);
    b_off1m   <= abht_pkg::mag33(off1);
    b_off2m   <= abht_pkg::mag33(off2);
    b_a_pos   <= !a_a[XW-1] && a_a != '0;
    b_a_zero  <= a_a == '0;
    b_v_zero  <= a_v == '0;
    b_ppos1   <= off1 != '0 && ((!a_a[XW-1] && a_a != '0) == (!off1[XW] && off1 != '0));
    b_ppos2   <= off2 != '0 && ((!a_a[XW-1] && a_a != '0) == (!off2[XW] && off2 != '0));
    b_on_up   <= off1 == '0;
    b_on_dn   <= off2 == '0;
    // moving out through the wall it sits on
    b_exit    <= (off1 == '0 && !a_v[XW-1] && a_v != '0) || (off2 == '0 && a_v[XW-1]);
    b_dist    <= wall_gap[XW-1:0];
    b_dist_ok <= !wall_gap[XW];
  end

  // stage c: products
  logic                c_vld;
  logic [2*XW-1:0]     c_v2, c_p1, c_p2;
  abht_pkg::sq_side_t  c_side;
  logic                c_ppos1, c_ppos2, c_on_up, c_on_dn;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else begin
      c_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    c_v2            <= b_vmag * b_vmag;
    c_p1            <= b_amag * b_off1m;
    c_p2            <= b_amag * b_off2m;
    c_ppos1         <= b_ppos1;
    c_ppos2         <= b_ppos2;
    c_on_up         <= b_on_up;
    c_on_dn         <= b_on_dn;
    c_side.v        <= b_v;
    c_side.a_pos    <= b_a_pos;
    c_side.a_zero   <= b_a_zero;
    c_side.v_zero   <= b_v_zero;
    c_side.fz       <= b_a_zero ? b_v_zero : b_exit;
    c_side.en       <= 2'b00;
    c_side.span     <= b_dist;
    c_side.dist_ok  <= b_dist_ok;
    c_side.den      <= b_a_zero ? b_vmag : b_amag;
  end

  // stage d: discriminants for both walls
  logic [2*XW:0]        pm1, pm2, v2e;
  logic [DW-1:0]        dd1, dd2;
  logic                 ok1, ok2;
  abht_pkg::sq_side_t   d_side_next;

  always_comb begin
    pm1 = {c_p1, 1'b0};
    pm2 = {c_p2, 1'b0};
    v2e = {1'b0, c_v2};
    if (c_ppos1) begin
      ok1 = pm1 <= v2e;
      dd1 = {1'b0, v2e - pm1};
    end else begin
      ok1 = 1'b1;
      dd1 = {2'b00, c_v2} + {1'b0, pm1};
    end
    if (c_ppos2) begin
      ok2 = pm2 <= v2e;
      dd2 = {1'b0, v2e - pm2};
    end else begin
      ok2 = 1'b1;
      dd2 = {2'b00, c_v2} + {1'b0, pm2};
    end
    d_side_next    = c_side;
    d_side_next.en = {ok2 && !c_on_dn, ok1 && !c_on_up};
  end

  logic                 d_vld;
  logic [1:0][DW-1:0]   d_rad;
  abht_pkg::sq_side_t   d_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else begin
      d_vld <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    d_rad[0] <= dd1;
    d_rad[1] <= dd2;
    d_side   <= d_side_next;
  end

  logic                 s_vld;
  logic [1:0][RW-1:0]   s_root;
  abht_pkg::sq_side_t   s_side;

  abht_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .vld_in   (d_vld),
    .rad_in   (d_rad),
    .side_in  (d_side),
    .vld_out  (s_vld),
    .root_out (s_root),
    .side_out (s_side)
  );

  // stage e: candidate numerators, four lanes
  logic signed [MW:0]   n_s [L];
  logic signed [MW:0]   v35;
  logic [L-1:0]         keep;
  logic [L-1:0][MW-1:0] nmag;

  always_comb begin
    v35 = {{(MW+1-XW){s_side.v[XW-1]}}, s_side.v};
    for (int w = 0; w < 2; w++) begin
      n_s[2*w]   = -$signed({2'b00, s_root[w]}) - v35;
      n_s[2*w+1] = $signed({2'b00, s_root[w]}) - v35;
    end
    for (int l = 0; l < L; l++) begin
      nmag[l] = abht_pkg::mag35(n_s[l]);
      keep[l] = s_side.en[l/2] &&
                (n_s[l] == '0 || ((!n_s[l][MW]) == s_side.a_pos));
    end
    if (s_side.a_zero) begin
      keep    = '0;
      keep[0] = !s_side.v_zero && s_side.dist_ok;
      nmag[0] = {{(MW-XW){1'b0}}, s_side.span};
    end
  end

  logic                 e_vld;
  logic [L-1:0][MW-1:0] e_num;
  logic [XW-1:0]        e_den;
  abht_pkg::dv_side_t   e_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else begin
      e_vld <= s_vld;
    end
  end

  always_ff @(posedge clk) begin
    e_num       <= nmag;
    e_den       <= s_side.den;
    e_side.keep <= keep;
    e_side.fz   <= s_side.fz;
  end

  logic                 q_vld;
  logic [L-1:0][QW-1:0] q_t;
  abht_pkg::dv_side_t   q_side;

  abht_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .vld_in   (e_vld),
    .num_in   (e_num),
    .den_in   (e_den),
    .side_in  (e_side),
    .vld_out  (q_vld),
    .q_out    (q_t),
    .side_out (q_side)
  );

  // first level of the minimum tree
  logic            m_vld, m_fz;
  logic [1:0]      m_found;
  logic [1:0][QW-1:0] m_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else begin
      m_vld <= q_vld;
    end
  end

  always_ff @(posedge clk) begin
    m_fz <= q_side.fz;
    for (int p = 0; p < 2; p++) begin
      m_found[p] <= q_side.keep[2*p] || q_side.keep[2*p+1];
      if (q_side.keep[2*p] && (!q_side.keep[2*p+1] || q_t[2*p] < q_t[2*p+1])) begin
        m_t[p] <= q_t[2*p];
      end else begin
        m_t[p] <= q_t[2*p+1];
      end
    end
  end

  // final minimum and result formatting
  logic [QW-1:0] best;
  logic          found;

  always_comb begin
    found = m_fz || m_found[0] || m_found[1];
    if (m_fz) begin
      best = '0;
    end else if (m_found[0] && (!m_found[1] || m_t[0] < m_t[1])) begin
      best = m_t[0];
    end else begin
      best = m_t[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= m_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!found) begin
      duration  <= '1;
      no_hit    <= 1'b1;
      saturated <= 1'b0;
    end else if (best[QW-1:XW] != '0) begin
      duration  <= '1;
      no_hit    <= 1'b0;
      saturated <= 1'b1;
    end else begin
      duration  <= best[XW-1:0];
      no_hit    <= 1'b0;
      saturated <= 1'b0;
    end
  end

`include "axis_boundary_hit_time_top_assert.svh"

  `ABHT_CHECK(a_latency, start |-> ##LAT done, "result beat missing after start")
  `ABHT_CHECK(a_flags, done |-> !(no_hit && saturated), "no_hit and saturated both set")
  `ABHT_CHECK(a_nohit_ones, done && no_hit |-> duration == '1, "no_hit without all ones")
  `ABHT_CHECK(a_sat_ones, done && saturated |-> duration == '1, "saturated without all ones")
  `ABHT_CHECK_ALWAYS(a_reset_clear, rst |=> !done, "done right after reset")

endmodule
`default_nettype wire

[src/abht_sqrt.sv]
`default_nettype none
module abht_sqrt (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  vld_in,
  input  wire logic [1:0][abht_pkg::RAD_W-1:0]       rad_in,
  input  wire abht_pkg::sq_side_t                    side_in,
  output logic                                       vld_out,
  output logic [1:0][abht_pkg::ROOT_W-1:0]           root_out,
  output abht_pkg::sq_side_t                         side_out
);

  localparam int N  = abht_pkg::SQ_STEPS;
  localparam int RW = abht_pkg::REM_W;
  localparam int QW = abht_pkg::ROOT_W;
  localparam int DW = abht_pkg::RAD_W;

  logic                vld  [1:N];
  logic [1:0][DW-1:0]  rad  [1:N];
  logic [1:0][RW-1:0]  rem  [1:N];
  logic [1:0][QW-1:0]  root [1:N];
  abht_pkg::sq_side_t  side [1:N];

  // one result bit per stage, two lanes side by side
  for (genvar k = 0; k < N; k++) begin : g_step
    logic               cur_vld;
    logic [1:0][DW-1:0] cur_rad;
    logic [1:0][RW-1:0] cur_rem;
    logic [1:0][QW-1:0] cur_root;
    abht_pkg::sq_side_t cur_side;
    logic [1:0][RW-1:0] r;
    logic [1:0][RW-1:0] trial;
    logic [1:0]         ge;

    if (k == 0) begin : g_src
      assign cur_vld  = vld_in;
      assign cur_rad  = rad_in;
      assign cur_rem  = '0;
      assign cur_root = '0;
      assign cur_side = side_in;
    end else begin : g_src
      assign cur_vld  = vld[k];
      assign cur_rad  = rad[k];
      assign cur_rem  = rem[k];
      assign cur_root = root[k];
      assign cur_side = side[k];
    end

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        r[l]     = {cur_rem[l][RW-3:0], cur_rad[l][DW-1:DW-2]};
        trial[l] = {{(RW-QW-2){1'b0}}, cur_root[l], 2'b01};
        ge[l]    = r[l] >= trial[l];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= cur_vld;
      end
    end

    always_ff @(posedge clk) begin
      for (int l = 0; l < 2; l++) begin
        rem[k+1][l]  <= ge[l] ? (r[l] - trial[l]) : r[l];
        root[k+1][l] <= {cur_root[l][QW-2:0], ge[l]};
        rad[k+1][l]  <= {cur_rad[l][DW-3:0], 2'b00};
      end
      side[k+1] <= cur_side;
    end
  end

  assign vld_out  = vld[N];
  assign root_out = root[N];
  assign side_out = side[N];

endmodule
`default_nettype wire

[src/abht_div.sv]
`default_nettype none
module abht_div #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                                                   clk,
  input  wire logic                                                   rst,
  input  wire logic                                                   vld_in,
  input  wire logic [abht_pkg::NUM_LANES-1:0][abht_pkg::MAG_W-1:0]    num_in,
  input  wire logic [abht_pkg::XW-1:0]                                den_in,
  input  wire abht_pkg::dv_side_t                                     side_in,
  output logic                                                        vld_out,
  output logic [abht_pkg::NUM_LANES-1:0][abht_pkg::MAG_W+FRAC_BITS-1:0] q_out,
  output abht_pkg::dv_side_t                                          side_out
);

  localparam int L  = abht_pkg::NUM_LANES;
  localparam int XW = abht_pkg::XW;
  localparam int DW = abht_pkg::MAG_W + FRAC_BITS;

  logic                 vld  [1:DW];
  logic [L-1:0][DW-1:0] dvd  [1:DW];
  logic [L-1:0][XW-1:0] rem  [1:DW];
  logic [L-1:0][DW-1:0] quo  [1:DW];
  logic [XW-1:0]        den  [1:DW];
  abht_pkg::dv_side_t   side [1:DW];

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < DW; k++) begin : g_step
    logic                 cur_vld;
    logic [L-1:0][DW-1:0] cur_dvd;
    logic [L-1:0][XW-1:0] cur_rem;
    logic [L-1:0][DW-1:0] cur_quo;
    logic [XW-1:0]        cur_den;
    abht_pkg::dv_side_t   cur_side;
    logic [L-1:0][XW:0]   r;
    logic [L-1:0]         ge;

    if (k == 0) begin : g_src
      assign cur_vld  = vld_in;
      assign cur_rem  = '0;
      assign cur_quo  = '0;
      assign cur_den  = den_in;
      assign cur_side = side_in;
      for (genvar l = 0; l < L; l++) begin : g_lane
        assign cur_dvd[l] = {num_in[l], {FRAC_BITS{1'b0}}};
      end
    end else begin : g_src
      assign cur_vld  = vld[k];
      assign cur_dvd  = dvd[k];
      assign cur_rem  = rem[k];
      assign cur_quo  = quo[k];
      assign cur_den  = den[k];
      assign cur_side = side[k];
    end

    always_comb begin
      for (int l = 0; l < L; l++) begin
        r[l]  = {cur_rem[l], cur_dvd[l][DW-1]};
        ge[l] = r[l] >= {1'b0, cur_den};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= cur_vld;
      end
    end

    always_ff @(posedge clk) begin
      for (int l = 0; l < L; l++) begin
        rem[k+1][l] <= ge[l] ? XW'(r[l] - {1'b0, cur_den}) : r[l][XW-1:0];
        quo[k+1][l] <= {cur_quo[l][DW-2:0], ge[l]};
        dvd[k+1][l] <= {cur_dvd[l][DW-2:0], 1'b0};
      end
      den[k+1]  <= cur_den;
      side[k+1] <= cur_side;
    end
  end

  assign vld_out  = vld[DW];
  assign q_out    = quo[DW];
  assign side_out = side[DW];

endmodule
`default_nettype wire
